// File: hw/rtl/assert_macros.svh
// Assertion helpers included by multi_channel_blink_timer_unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold in the same cycle whenever the antecedent holds.
`define MCBT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Property that must hold in the cycle after the antecedent holds.
`define MCBT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/mcbt_pkg.sv
package mcbt_pkg;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_DELETE = 2'd1,
    OP_UPDATE = 2'd2,
    OP_RUN    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    MODE_DEAD = 2'd0,
    MODE_OFF  = 2'd1,
    MODE_ON   = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    KIND_ANSWER = 2'd0,
    KIND_TOGGLE = 2'd1,
    KIND_DONE   = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_SLOT  = 2'd1,
    STAT_INACTIVE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_ANSWER
  } state_t;

  // One light's stored state, as it travels around the ring.
  typedef struct packed {
    mode_t       mode;
    logic [15:0] tick;
    logic [15:0] on_span;
    logic [15:0] off_span;
    logic [23:0] on_rgb;
    logic [23:0] off_rgb;
    logic [7:0]  pidx;
  } light_rec_t;

endpackage

// File: hw/rtl/multi_channel_blink_timer_unit.sv
// Table of blinking lights, driven by one request channel and one result
// channel, both valid/ready. A request carries an opcode (add, delete,
// update, run one frame tick) plus the light parameters. Each request
// yields one or more results; the final one of a request has out_last set.
// The light records sit in a ring of LIGHTS cells that rotates by one
// position per step, so every request walks the whole table once through a
// single processing point at the head of the ring. A request is accepted,
// then passes through LIGHTS sweep steps, and then presents the command
// answer or tick-done result. The next request is taken in the cycle after
// the closing result is loaded, while that result may still sit in the
// output register. After LIGHTS steps the ring is back in its original
// order.
// Reset marks every light dead; no clearing pass is needed.
// When the receiver stalls, a pending result holds in the output register
// and the ring freezes until it has been taken, so nothing is lost.
module multi_channel_blink_timer_unit #(
  parameter int LIGHTS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [3:0]  in_light_id,
  input  logic [7:0]  in_palette_slot,
  input  logic [23:0] in_lit_color,
  input  logic [23:0] in_dark_color,
  input  logic [15:0] in_lit_frames,
  input  logic [15:0] in_dark_frames,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [1:0]  out_status,
  output logic [3:0]  out_slot,
  output logic [7:0]  out_shown_index,
  output logic [23:0] out_shown_color,
  output logic        out_now_lit,
  output logic        out_last
);
  import mcbt_pkg::*;

  `include "assert_macros.svh"

  localparam int SW = (LIGHTS > 1) ? $clog2(LIGHTS) : 1;

  // Sequencer state and the latched request.
  state_t      state_r, state_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic        found_r, found_nxt;
  logic [3:0]  found_slot_r, found_slot_nxt;
  op_t         cmd_op_r;
  logic [3:0]  cmd_id_r;
  logic [7:0]  cmd_pidx_r;
  logic [23:0] cmd_lit_c_r;
  logic [23:0] cmd_dark_c_r;
  logic [15:0] cmd_lit_f_r;
  logic [15:0] cmd_dark_f_r;

  // Output register.
  logic        out_valid_r;
  kind_t       out_kind_r;
  status_t     out_status_r;
  logic [3:0]  out_slot_r;
  logic [7:0]  out_index_r;
  logic [23:0] out_color_r;
  logic        out_lit_r;
  logic        out_last_r;

  // Control decoded from the state.
  logic        accept;
  logic        can_step;
  logic        step_go;
  logic        ans_go;
  logic        last_slot;

  // The ring of cells.
  light_rec_t  cell_out [LIGHTS];
  light_rec_t  head;
  light_rec_t  new_rec;

  // Head processing results.
  logic        head_live;
  logic        id_hit;
  logic        emit;
  logic [16:0] cnt_inc;
  logic [15:0] cur_span;
  logic [SW+3:0] id_ext;
  logic [SW+3:0] slot_ext;
  logic [3:0]  slot4;

  kind_t       res_kind;
  status_t     res_status;
  logic [3:0]  res_slot;
  logic [7:0]  res_index;
  logic [23:0] res_color;
  logic        res_lit;
  logic        res_last;

  // A step may run only when the output register can take whatever it
  // produces this cycle.
  assign can_step  = !out_valid_r || out_ready;
  assign last_slot = (slot_r == SW'(LIGHTS - 1));

  // Next-state logic of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (can_step && last_slot) begin
          state_nxt = ST_ANSWER;
        end
      end
      ST_ANSWER: begin
        if (can_step) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    in_ready = 1'b0;
    step_go  = 1'b0;
    ans_go   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SWEEP: begin
        step_go = can_step;
      end
      ST_ANSWER: begin
        ans_go = can_step;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign accept = in_valid && in_ready;

  // Ring of cells: each cell takes its upper neighbor, and the top cell
  // takes the record that the head logic has just processed.
  for (genvar i = 0; i < LIGHTS; i++) begin : g_ring
    light_rec_t rec_feed;
    if (i == LIGHTS - 1) begin : g_tail
      assign rec_feed = new_rec;
    end else begin : g_link
      assign rec_feed = cell_out[i + 1];
    end
    mcbt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift_en (step_go),
      .rec_in   (rec_feed),
      .rec_out  (cell_out[i])
    );
  end

  assign head      = cell_out[0];
  assign head_live = (head.mode == MODE_OFF) || (head.mode == MODE_ON);
  assign id_ext    = {{SW{1'b0}}, cmd_id_r};
  assign slot_ext  = {4'b0000, slot_r};
  assign id_hit    = (id_ext == slot_ext);
  assign slot4     = slot_ext[3:0];
  assign cur_span  = (head.mode == MODE_ON) ? head.on_span : head.off_span;
  assign cnt_inc   = {1'b0, head.tick} + 17'd1;

  // Work on the record at the head of the ring, and form the result of
  // the step or of the closing answer.
  always_comb begin
    new_rec        = head;
    emit           = 1'b0;
    found_nxt      = found_r;
    found_slot_nxt = found_slot_r;
    res_kind       = KIND_ANSWER;
    res_status     = STAT_OK;
    res_slot       = 4'd0;
    res_index      = 8'd0;
    res_color      = 24'd0;
    res_lit        = 1'b0;
    res_last       = 1'b0;

    if (state_r == ST_SWEEP) begin
      case (cmd_op_r)
        OP_ADD: begin
          if (!found_r && !head_live) begin
            new_rec.mode     = MODE_OFF;
            new_rec.tick     = 16'd0;
            new_rec.on_span  = cmd_lit_f_r;
            new_rec.off_span = cmd_dark_f_r;
            new_rec.on_rgb   = cmd_lit_c_r;
            new_rec.off_rgb  = cmd_dark_c_r;
            new_rec.pidx     = cmd_pidx_r;
            found_nxt        = 1'b1;
            found_slot_nxt   = slot4;
          end
        end
        OP_DELETE: begin
          if (id_hit && head_live) begin
            new_rec.mode = MODE_DEAD;
            found_nxt    = 1'b1;
          end
        end
        OP_UPDATE: begin
          if (id_hit && head_live) begin
            new_rec.on_span  = cmd_lit_f_r;
            new_rec.off_span = cmd_dark_f_r;
            new_rec.on_rgb   = cmd_lit_c_r;
            new_rec.off_rgb  = cmd_dark_c_r;
            found_nxt        = 1'b1;
          end
        end
        OP_RUN: begin
          if (head_live) begin
            if (cnt_inc >= {1'b0, cur_span}) begin
              new_rec.tick = 16'd0;
              emit         = 1'b1;
              res_kind     = KIND_TOGGLE;
              res_slot     = slot4;
              res_index    = head.pidx;
              if (head.mode == MODE_OFF) begin
                new_rec.mode = MODE_ON;
                res_color    = head.on_rgb;
                res_lit      = 1'b1;
              end else begin
                new_rec.mode = MODE_OFF;
                res_color    = head.off_rgb;
              end
            end else begin
              new_rec.tick = cnt_inc[15:0];
            end
          end
        end
        default: begin
          new_rec = head;
        end
      endcase
    end else if (state_r == ST_ANSWER) begin
      res_last = 1'b1;
      case (cmd_op_r)
        OP_ADD: begin
          res_status = found_r ? STAT_OK : STAT_NO_SLOT;
          res_slot   = found_r ? found_slot_r : 4'd0;
        end
        OP_DELETE, OP_UPDATE: begin
          res_status = found_r ? STAT_OK : STAT_INACTIVE;
          res_slot   = cmd_id_r;
        end
        OP_RUN: begin
          res_kind = KIND_DONE;
        end
        default: begin
          res_kind = KIND_ANSWER;
        end
      endcase
    end
  end

  assign slot_nxt = accept ? '0 : (step_go ? SW'(slot_r + 1'b1) : slot_r);

  // Sequencer control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      slot_r       <= '0;
      found_r      <= 1'b0;
      found_slot_r <= 4'd0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
      if (accept) begin
        found_r      <= 1'b0;
        found_slot_r <= 4'd0;
      end else if (step_go) begin
        found_r      <= found_nxt;
        found_slot_r <= found_slot_nxt;
      end
    end
  end

  // The request is held for the whole sweep.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_op_r     <= op_t'(in_op);
      cmd_id_r     <= in_light_id;
      cmd_pidx_r   <= in_palette_slot;
      cmd_lit_c_r  <= in_lit_color;
      cmd_dark_c_r <= in_dark_color;
      cmd_lit_f_r  <= in_lit_frames;
      cmd_dark_f_r <= in_dark_frames;
    end
  end

  // Output register: loaded by a toggling step or by the closing answer,
  // emptied when the receiver takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((step_go && emit) || ans_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((step_go && emit) || ans_go) begin
      out_kind_r   <= res_kind;
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_index_r  <= res_index;
      out_color_r  <= res_color;
      out_lit_r    <= res_lit;
      out_last_r   <= res_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = out_kind_r;
  assign out_status      = out_status_r;
  assign out_slot        = out_slot_r;
  assign out_shown_index = out_index_r;
  assign out_shown_color = out_color_r;
  assign out_now_lit     = out_lit_r;
  assign out_last        = out_last_r;

  // The ring advances exactly one position per sweep step.
  `MCBT_ASSERT_NEXT(a_slot_advance, step_go && !last_slot,
    slot_r == SW'($past(slot_r) + 1'b1), "sweep position did not advance")

  // Only a run tick produces results in the middle of a sweep.
  `MCBT_ASSERT_NOW(a_emit_run_only, step_go && emit, cmd_op_r == OP_RUN,
    "result emitted during a non-run sweep")

  // The ring must not move while a result is waiting on the receiver.
  `MCBT_ASSERT_NOW(a_freeze_on_stall, out_valid_r && !out_ready, !step_go && !ans_go,
    "table advanced while output was stalled")

  // The closing answer ends the request and frees the request channel.
  `MCBT_ASSERT_NEXT(a_answer_last, ans_go,
    out_valid_r && out_last_r && state_r == ST_IDLE, "closing result missing or not last")

endmodule

// File: hw/rtl/mcbt_cell.sv
module mcbt_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                shift_en,
  input  mcbt_pkg::light_rec_t rec_in,
  output mcbt_pkg::light_rec_t rec_out
);
  import mcbt_pkg::*;

  light_rec_t rec_r;

  // Only the mode needs a reset: every other field is rewritten by an add
  // before a light becomes live.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.mode <= MODE_DEAD;
    end else if (shift_en) begin
      rec_r.mode <= rec_in.mode;
    end
    if (shift_en) begin
      rec_r.tick     <= rec_in.tick;
      rec_r.on_span  <= rec_in.on_span;
      rec_r.off_span <= rec_in.off_span;
      rec_r.on_rgb   <= rec_in.on_rgb;
      rec_r.off_rgb  <= rec_in.off_rgb;
      rec_r.pidx     <= rec_in.pidx;
    end
  end

  assign rec_out = rec_r;

endmodule
